// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/lfidr_pkg.sv =====
`timescale 1ns / 1ps

package lfidr_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_RES,
        S_SLOT,
        S_PUT,
        S_SHRINK,
        S_KWAIT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        CMD_PUT       = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_ID_OF_KEY = 3'd2,
        CMD_BOUND     = 3'd3,
        CMD_KEY_OF_ID = 3'd4,
        CMD_PEEK      = 3'd5,
        CMD_CLEAR     = 3'd6,
        CMD_NONE      = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_RANGE   = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

endpackage

// ===== sv/lowest_free_id_registry_core.sv =====
`timescale 1ns / 1ps
// channel   valid     ready     payload
// request   i_valid   o_ready   i_cmd i_domain i_key i_id
// result    o_valid   i_ready   o_status o_id_out o_key_out o_bound
//
// one request at a time; o_ready is high only in idle
// put, remove and id-of-key sweep the reverse store, one entry a cycle through
// its read port; put then searches the domain for a free slot, and remove may
// then shrink the id bound; other commands do not sweep; a pending result
// holds the last state
// synchronous active-low reset clears all valid, active, count and bound state

`include "assert_macros.svh"

module lowest_free_id_registry_core #(
    parameter int DOMAINS   = 8,
    parameter int SLOTS     = 32,
    parameter int REV_DEPTH = 64,
    parameter int KEY_BITS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [2:0]  i_domain,
    input  logic [63:0] i_key,
    input  logic [5:0]  i_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_id_out,
    output logic [63:0] o_key_out,
    output logic [5:0]  o_bound
);
    import lfidr_pkg::*;

    localparam int DW  = (DOMAINS > 1) ? $clog2(DOMAINS) : 1;
    localparam int SW  = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int RW  = $clog2(REV_DEPTH);
    localparam int RCW = $clog2(REV_DEPTH + 1);
    localparam int NS  = DOMAINS * SLOTS;
    localparam int AW  = $clog2(NS);
    localparam int MW  = KEY_BITS + DW + SW;

    // domain number wraps modulo the domain count
    function automatic logic [DW-1:0] wrap_dom(input logic [2:0] v);
        logic [7:0] t;
        t = {5'd0, v};
        for (int i = 0; i < 8; i++) begin
            if (32'(t) >= DOMAINS) begin
                t = 8'(32'(t) - DOMAINS);
            end
        end
        return DW'(t);
    endfunction

    function automatic logic [AW-1:0] saddr(input logic [DW-1:0] dd, input logic [SW-1:0] ss);
        return AW'(AW'(dd) * AW'(SLOTS) + AW'(ss));
    endfunction

    // control state
    t_state            r_state, n_state;
    logic              r_o_valid;
    logic [NS-1:0]     r_slot_active;
    logic [CW-1:0]     r_slot_count [DOMAINS];
    logic [CW-1:0]     r_id_bound   [DOMAINS];
    logic [DOMAINS-1:0] r_domain_known;
    logic [REV_DEPTH-1:0] r_rev_valid;
    logic [REV_DEPTH-1:0] r_rev_cleared;

    // request and working registers
    t_cmd              r_cmd;
    logic [DW-1:0]     r_dom;
    logic [KEY_BITS-1:0] r_key;
    logic [5:0]        r_id;
    logic [RCW-1:0]    r_idx;
    logic              r_pend;
    logic [RW-1:0]     r_pend_idx;
    logic              r_hit;
    logic [RW-1:0]     r_hit_idx;
    logic [DW-1:0]     r_hit_dom;
    logic [SW-1:0]     r_hit_slot;
    logic              r_free_found;
    logic [RW-1:0]     r_free_idx;
    logic [CW-1:0]     r_s;
    logic              r_new;
    logic [DW-1:0]     r_bd;
    t_status           r_status;
    logic [CW-1:0]     r_id_out;
    logic [KEY_BITS-1:0] r_key_out;

    // output registers
    logic [2:0]        r_o_status;
    logic [5:0]        r_o_id_out;
    logic [63:0]       r_o_key_out;
    logic [5:0]        r_o_bound;

    // memories
    logic [KEY_BITS-1:0] slot_mem [NS];
    logic [MW-1:0]       rev_mem  [REV_DEPTH];
    logic [KEY_BITS-1:0] r_slot_rd;
    logic [MW-1:0]       r_rev_rd;

    // derived
    logic [CW-1:0]     cnt, bnd, sh_b;
    logic [5:0]        idm1;
    logic              koi_go, koi_range, koi_act;
    logic [AW-1:0]     koi_addr, pk_addr, sc_addr, sh_addr, put_addr, rem_addr;
    logic              pk_go, sc_lt, sc_free, sh_go, scan_more, scan_match, bound_top;
    logic [KEY_BITS-1:0] rv_key;
    logic [DW-1:0]     rv_dom;
    logic [SW-1:0]     rv_slot;
    logic              out_free;

    always_comb begin
        cnt        = r_slot_count[r_dom];
        bnd        = r_id_bound[r_dom];
        idm1       = r_id - 6'd1;
        koi_go     = (r_id != 6'd0) && r_domain_known[r_dom];
        koi_range  = (32'(idm1) >= 32'(cnt)) || (32'(idm1) >= SLOTS);
        koi_addr   = saddr(r_dom, SW'(idm1));
        koi_act    = r_slot_active[koi_addr];
        pk_addr    = saddr(r_dom, SW'(bnd - CW'(1)));
        pk_go      = (bnd != '0) && (32'(bnd) <= SLOTS) && r_slot_active[pk_addr];
        sc_addr    = saddr(r_dom, SW'(r_s));
        sc_lt      = r_s < cnt;
        sc_free    = !r_slot_active[sc_addr];
        sh_b       = r_id_bound[r_bd];
        sh_addr    = saddr(r_bd, SW'(sh_b - CW'(1)));
        sh_go      = (sh_b != '0) && !r_slot_active[sh_addr];
        put_addr   = saddr(r_dom, SW'(r_s));
        rem_addr   = saddr(r_hit_dom, r_hit_slot);
        bound_top  = r_id_bound[r_hit_dom] == (CW'(r_hit_slot) + CW'(1));
        scan_more  = 32'(r_idx) < REV_DEPTH;
        rv_key     = r_rev_rd[MW-1 -: KEY_BITS];
        rv_dom     = r_rev_rd[SW +: DW];
        rv_slot    = r_rev_rd[SW-1:0];
        scan_match = r_pend && r_rev_valid[r_pend_idx] && (rv_key == r_key);
        out_free   = !r_o_valid || i_ready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_START;
            end
            S_START: begin
                unique case (r_cmd)
                    CMD_PUT, CMD_REMOVE: n_state = S_SCAN;
                    CMD_ID_OF_KEY: n_state = (r_key == '0) ? S_DONE : S_SCAN;
                    CMD_KEY_OF_ID: n_state = (koi_go && !koi_range && koi_act) ? S_KWAIT : S_DONE;
                    CMD_PEEK: n_state = pk_go ? S_KWAIT : S_DONE;
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (!r_pend && !scan_more) n_state = S_RES;
            end
            S_RES: begin
                if (r_cmd == CMD_PUT) begin
                    n_state = r_hit ? S_DONE : S_SLOT;
                end else if (r_cmd == CMD_REMOVE && r_hit && !r_rev_cleared[r_hit_idx]
                             && bound_top) begin
                    n_state = S_SHRINK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SLOT: begin
                if (sc_lt) begin
                    if (sc_free) n_state = S_PUT;
                end else begin
                    n_state = (32'(cnt) >= SLOTS) ? S_DONE : S_PUT;
                end
            end
            S_PUT:    n_state = S_DONE;
            S_SHRINK: n_state = sh_go ? S_SHRINK : S_DONE;
            S_KWAIT:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready   = (r_state == S_IDLE);
        o_valid   = r_o_valid;
        o_status  = r_o_status;
        o_id_out  = r_o_id_out;
        o_key_out = r_o_key_out;
        o_bound   = r_o_bound;
    end

    // control state and registry bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_o_valid      <= 1'b0;
            r_slot_active  <= '0;
            r_domain_known <= '0;
            r_rev_valid    <= '0;
            r_rev_cleared  <= '0;
            for (int i = 0; i < DOMAINS; i++) begin
                r_slot_count[i] <= '0;
                r_id_bound[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            // load a new result, else drop the one just taken
            r_o_valid <= (r_state == S_DONE && out_free) || (r_o_valid && !i_ready);
            case (r_state)
                S_START: begin
                    if (r_cmd == CMD_CLEAR) begin
                        r_rev_cleared <= r_rev_cleared | r_rev_valid;
                        r_slot_active <= '0;
                        for (int i = 0; i < DOMAINS; i++) begin
                            r_slot_count[i] <= '0;
                            r_id_bound[i]   <= '0;
                        end
                    end
                end
                S_RES: begin
                    if (r_cmd == CMD_REMOVE && r_hit) begin
                        r_rev_valid[r_hit_idx] <= 1'b0;
                        if (r_rev_cleared[r_hit_idx]) begin
                            r_rev_cleared[r_hit_idx] <= 1'b0;
                        end else begin
                            r_slot_active[rem_addr] <= 1'b0;
                        end
                    end
                end
                S_PUT: begin
                    if (r_free_found) begin
                        if (r_new) r_slot_count[r_dom] <= cnt + CW'(1);
                        r_slot_active[put_addr]   <= 1'b1;
                        r_domain_known[r_dom]     <= 1'b1;
                        if (bnd < r_s + CW'(1)) r_id_bound[r_dom] <= r_s + CW'(1);
                        r_rev_valid[r_free_idx]   <= 1'b1;
                        r_rev_cleared[r_free_idx] <= 1'b0;
                    end
                end
                S_SHRINK: begin
                    if (sh_go) r_id_bound[r_bd] <= sh_b - CW'(1);
                end
                default: ;
            endcase
        end
    end

    // request capture, sweep and result registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_cmd <= t_cmd'(i_cmd);
                    r_dom <= wrap_dom(i_domain);
                    r_key <= i_key[KEY_BITS-1:0];
                    r_id  <= i_id;
                end
            end
            S_START: begin
                r_status     <= (r_cmd == CMD_KEY_OF_ID && koi_go && koi_range) ?
                                ST_RANGE : ST_OK;
                r_id_out     <= '0;
                r_key_out    <= '0;
                r_bd         <= r_dom;
                r_idx        <= '0;
                r_pend       <= 1'b0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_s          <= '0;
                r_new        <= 1'b0;
            end
            S_SCAN: begin
                if (scan_match) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_pend_idx;
                    r_hit_dom  <= rv_dom;
                    r_hit_slot <= rv_slot;
                end
                if (scan_more) begin
                    r_pend     <= 1'b1;
                    r_pend_idx <= RW'(r_idx);
                    r_idx      <= r_idx + RCW'(1);
                    if (!r_free_found && !r_rev_valid[RW'(r_idx)]) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= RW'(r_idx);
                    end
                end else begin
                    r_pend <= 1'b0;
                end
            end
            S_RES: begin
                unique case (r_cmd)
                    CMD_PUT: begin
                        if (r_hit) r_status <= ST_DUP;
                    end
                    CMD_REMOVE, CMD_ID_OF_KEY: begin
                        if (!r_hit) begin
                            r_status <= ST_UNKNOWN;
                        end else if (!r_rev_cleared[r_hit_idx]) begin
                            r_bd     <= r_hit_dom;
                            r_id_out <= CW'(r_hit_slot) + CW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            S_SLOT: begin
                if (sc_lt) begin
                    if (!sc_free) r_s <= r_s + CW'(1);
                end else begin
                    r_new <= 1'b1;
                    if (32'(cnt) >= SLOTS) r_status <= ST_FULL;
                end
            end
            S_PUT: begin
                if (!r_free_found) r_status <= ST_FULL;
                else r_id_out <= r_s + CW'(1);
            end
            S_KWAIT: r_key_out <= r_slot_rd;
            S_DONE: begin
                if (out_free) begin
                    r_o_status  <= r_status;
                    r_o_id_out  <= 6'(r_id_out);
                    r_o_key_out <= 64'(r_key_out);
                    r_o_bound   <= 6'(r_id_bound[r_bd]);
                end
            end
            default: ;
        endcase
    end

    // slot key store
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUT && r_free_found) slot_mem[put_addr] <= r_key;
        if (r_state == S_START) r_slot_rd <= slot_mem[(r_cmd == CMD_PEEK) ? pk_addr : koi_addr];
    end

    // reverse store: key, domain, slot
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUT && r_free_found) rev_mem[r_free_idx] <= {r_key, r_dom, SW'(r_s)};
        if (r_state == S_SCAN && scan_more) r_rev_rd <= rev_mem[RW'(r_idx)];
    end

    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_valid && o_ready, r_state == S_START)
    `ASSERT_NEXT(a_put_claims_rev, i_clk, i_rst_n, r_state == S_PUT && r_free_found,
        r_rev_valid[$past(r_free_idx)])
    `ASSERT_IMPLIES(a_count_range, i_clk, i_rst_n, r_state != S_IDLE,
        32'(r_slot_count[r_dom]) <= SLOTS)

endmodule

// ===== verif/lowest_free_id_registry_core_test.sv =====
`timescale 1ns / 1ps

module lowest_free_id_registry_core_test;
    import lfidr_pkg::*;

    localparam int NDOM = 8;
    localparam int NSLOT = 32;
    localparam int NREV = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int NKEYS = 96;

    typedef struct {
        t_status     status;
        logic [5:0]  id_out;
        logic [63:0] key_out;
        logic [5:0]  bound;
    } t_reg_answer;

    typedef struct {
        t_cmd        cmd;
        logic [2:0]  dom;
        logic [63:0] key;
        logic [5:0]  id;
        bit          typed;
        t_reg_answer ans;
    } t_drow;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [2:0]  i_cmd = 0;
    logic [2:0]  i_domain = 0;
    logic [63:0] i_key = 0;
    logic [5:0]  i_id = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [2:0]  o_status;
    logic [5:0]  o_id_out;
    logic [63:0] o_key_out;
    logic [5:0]  o_bound;

    lowest_free_id_registry_core u_top (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // mirror of the registry contents
    logic [63:0] mir_slot_key[NDOM][NSLOT];
    bit          mir_slot_act[NDOM][NSLOT];
    int          mir_count[NDOM];
    int          mir_bound[NDOM];
    bit          mir_known[NDOM];
    logic [63:0] mir_rev_key[NREV];
    bit          mir_rev_vld[NREV];
    bit          mir_rev_clr[NREV];
    int          mir_rev_dom[NREV];
    int          mir_rev_slot[NREV];

    t_reg_answer pending_answers[$];
    logic [63:0] key_pool[NKEYS];
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          quiet_cycles = 0;

    function automatic int lookup_key(logic [63:0] k);
        for (int i = 0; i < NREV; i++)
            if (mir_rev_vld[i] && mir_rev_key[i] == k) return i;
        return -1;
    endfunction

    // applies one request to the mirror and returns the answer it should get
    function automatic t_reg_answer registry_apply(t_cmd cmd, logic [2:0] dom,
                                                   logic [63:0] k, logic [5:0] id);
        t_reg_answer a;
        int d, bd, r, fr, s, idv;
        bit found;
        d = int'(dom);
        bd = d;
        idv = int'(id);
        a.status = ST_OK;
        a.id_out = '0;
        a.key_out = '0;
        case (cmd)
            CMD_PUT: begin
                if (lookup_key(k) >= 0) begin
                    a.status = ST_DUP;
                end else begin
                    fr = -1;
                    for (int i = 0; i < NREV; i++)
                        if (!mir_rev_vld[i] && fr < 0) fr = i;
                    found = 0;
                    s = mir_count[d];
                    for (int i = 0; i < mir_count[d]; i++)
                        if (!mir_slot_act[d][i] && !found) begin
                            found = 1;
                            s = i;
                        end
                    if ((!found && mir_count[d] >= NSLOT) || fr < 0) begin
                        a.status = ST_FULL;
                    end else begin
                        if (!found) mir_count[d]++;
                        mir_slot_key[d][s] = k;
                        mir_slot_act[d][s] = 1;
                        mir_known[d] = 1;
                        if (mir_bound[d] < s + 1) mir_bound[d] = s + 1;
                        mir_rev_vld[fr] = 1;
                        mir_rev_clr[fr] = 0;
                        mir_rev_key[fr] = k;
                        mir_rev_dom[fr] = d;
                        mir_rev_slot[fr] = s;
                        a.id_out = 6'(s + 1);
                    end
                end
            end
            CMD_REMOVE: begin
                r = lookup_key(k);
                if (r < 0) begin
                    a.status = ST_UNKNOWN;
                end else begin
                    mir_rev_vld[r] = 0;
                    if (mir_rev_clr[r]) begin
                        mir_rev_clr[r] = 0;
                    end else begin
                        bd = mir_rev_dom[r];
                        s = mir_rev_slot[r];
                        mir_slot_act[bd][s] = 0;
                        mir_slot_key[bd][s] = 0;
                        if (mir_bound[bd] == s + 1)
                            while (mir_bound[bd] > 0 && !mir_slot_act[bd][mir_bound[bd] - 1])
                                mir_bound[bd]--;
                        a.id_out = 6'(s + 1);
                    end
                end
            end
            CMD_ID_OF_KEY: begin
                if (k != 0) begin
                    r = lookup_key(k);
                    if (r < 0) a.status = ST_UNKNOWN;
                    else if (!mir_rev_clr[r]) begin
                        bd = mir_rev_dom[r];
                        a.id_out = 6'(mir_rev_slot[r] + 1);
                    end
                end
            end
            CMD_KEY_OF_ID: begin
                if (idv != 0 && mir_known[d]) begin
                    if (idv - 1 >= mir_count[d] || idv - 1 >= NSLOT) a.status = ST_RANGE;
                    else if (mir_slot_act[d][idv - 1]) a.key_out = mir_slot_key[d][idv - 1];
                end
            end
            CMD_PEEK: begin
                if (mir_bound[d] > 0 && mir_slot_act[d][mir_bound[d] - 1])
                    a.key_out = mir_slot_key[d][mir_bound[d] - 1];
            end
            CMD_CLEAR: begin
                for (int i = 0; i < NREV; i++)
                    if (mir_rev_vld[i]) mir_rev_clr[i] = 1;
                for (int i = 0; i < NDOM; i++) begin
                    mir_count[i] = 0;
                    mir_bound[i] = 0;
                    for (int j = 0; j < NSLOT; j++) begin
                        mir_slot_act[i][j] = 0;
                        mir_slot_key[i][j] = 0;
                    end
                end
            end
            default: ;
        endcase
        a.bound = 6'(mir_bound[bd]);
        return a;
    endfunction

    // drive one request, hold it until taken, then optionally go idle
    task automatic issue_request(t_cmd cmd, logic [2:0] dom, logic [63:0] k,
                                 logic [5:0] id, bit typed, t_reg_answer typed_ans);
        t_reg_answer a;
        i_valid <= 1;
        i_cmd <= cmd;
        i_domain <= dom;
        i_key <= k;
        i_id <= id;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        a = registry_apply(cmd, dom, k, id);
        pending_answers.push_back(typed ? typed_ans : a);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
            @(posedge i_clk);
        end
    endtask

    // result side: stall pattern follows the current phase
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= stall_pct);

    // outputs are sampled mid-cycle, the handshake completes at the next edge
    always @(negedge i_clk) begin
        t_reg_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            quiet_cycles <= 0;
            if (pending_answers.size() == 0) begin
                $display("%0t: result with nothing expected: st=%0d id=%0d key=%h bd=%0d",
                         $time, o_status, o_id_out, o_key_out, o_bound);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_status);
                    errors++;
                end
                if (o_id_out !== want.id_out) begin
                    $display("%0t: id_out expected %0d actual %0d", $time, want.id_out, o_id_out);
                    errors++;
                end
                if (o_key_out !== want.key_out) begin
                    $display("%0t: key_out expected %h actual %h", $time, want.key_out, o_key_out);
                    errors++;
                end
                if (o_bound !== want.bound) begin
                    $display("%0t: bound expected %0d actual %0d", $time, want.bound, o_bound);
                    errors++;
                end
            end
        end else if (i_valid && o_ready) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk)
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end

    function automatic t_reg_answer ans(t_status st, int idv, logic [63:0] kv, int bv);
        t_reg_answer a;
        a.status = st;
        a.id_out = 6'(idv);
        a.key_out = kv;
        a.bound = 6'(bv);
        return a;
    endfunction

    function automatic t_cmd random_cmd();
        int p;
        p = $urandom_range(99);
        if (p < 35) return CMD_PUT;
        if (p < 60) return CMD_REMOVE;
        if (p < 72) return CMD_ID_OF_KEY;
        if (p < 78) return CMD_BOUND;
        if (p < 90) return CMD_KEY_OF_ID;
        if (p < 98) return CMD_PEEK;
        if (p < 99) return CMD_CLEAR;
        return CMD_NONE;
    endfunction

    initial begin
        t_drow       plan[$];
        t_reg_answer none;
        logic [63:0] ones, alt;
        logic [2:0]  fill_dom;
        int          phase;
        ones = '1;
        alt = 64'hAAAA_AAAA_AAAA_AAAA;
        none = ans(ST_OK, 0, 0, 0);
        for (int i = 0; i < NKEYS; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = ones;
        key_pool[2] = 64'h5555_5555_5555_5555;
        key_pool[3] = alt;

        // directed cases: empty registry, extremes, duplicates, ranges, clear
        plan.push_back('{CMD_BOUND, 0, 0, 0, 1, ans(ST_OK, 0, 0, 0)});
        plan.push_back('{CMD_PEEK, 3, 0, 0, 1, ans(ST_OK, 0, 0, 0)});
        plan.push_back('{CMD_KEY_OF_ID, 0, 0, 5, 1, ans(ST_OK, 0, 0, 0)});
        plan.push_back('{CMD_ID_OF_KEY, 0, 0, 0, 1, ans(ST_OK, 0, 0, 0)});
        plan.push_back('{CMD_REMOVE, 0, 64'h1234, 0, 1, ans(ST_UNKNOWN, 0, 0, 0)});
        plan.push_back('{CMD_PUT, 0, ones, 0, 1, ans(ST_OK, 1, 0, 1)});
        plan.push_back('{CMD_PUT, 0, ones, 0, 1, ans(ST_DUP, 0, 0, 1)});
        plan.push_back('{CMD_PUT, 7, 0, 63, 1, ans(ST_OK, 1, 0, 1)});
        plan.push_back('{CMD_PUT, 0, alt, 0, 1, ans(ST_OK, 2, 0, 2)});
        plan.push_back('{CMD_KEY_OF_ID, 0, 0, 2, 1, ans(ST_OK, 0, alt, 2)});
        plan.push_back('{CMD_KEY_OF_ID, 0, 0, 63, 1, ans(ST_RANGE, 0, 0, 2)});
        plan.push_back('{CMD_KEY_OF_ID, 0, 0, 0, 1, ans(ST_OK, 0, 0, 2)});
        plan.push_back('{CMD_PEEK, 0, 0, 0, 1, ans(ST_OK, 0, alt, 2)});
        plan.push_back('{CMD_ID_OF_KEY, 5, ones, 0, 1, ans(ST_OK, 1, 0, 2)});
        plan.push_back('{CMD_REMOVE, 4, alt, 0, 1, ans(ST_OK, 2, 0, 1)});
        plan.push_back('{CMD_NONE, 5, ones, 63, 1, ans(ST_OK, 0, 0, 0)});
        plan.push_back('{CMD_KEY_OF_ID, 7, 0, 1, 0, none});
        plan.push_back('{CMD_CLEAR, 0, 0, 0, 1, ans(ST_OK, 0, 0, 0)});
        plan.push_back('{CMD_ID_OF_KEY, 3, ones, 0, 1, ans(ST_OK, 0, 0, 0)});
        plan.push_back('{CMD_PUT, 1, ones, 0, 1, ans(ST_DUP, 0, 0, 0)});
        plan.push_back('{CMD_REMOVE, 2, ones, 0, 1, ans(ST_OK, 0, 0, 0)});
        plan.push_back('{CMD_REMOVE, 2, 0, 0, 1, ans(ST_OK, 0, 0, 0)});
        plan.push_back('{CMD_PUT, 0, key_pool[2], 0, 1, ans(ST_OK, 1, 0, 1)});
        plan.push_back('{CMD_PEEK, 0, 0, 0, 0, none});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (plan[i])
            issue_request(plan[i].cmd, plan[i].dom, plan[i].key, plan[i].id,
                          plan[i].typed, plan[i].ans);

        // four idling phases; the first two each have a fill burst that frees the reverse
        // store, then overfills a single domain and the reverse store for both full cases
        for (phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 60 : (phase == 3) ? 7 : 0;
            stall_pct = (phase == 2) ? 60 : (phase == 3) ? 7 : 0;
            for (int n = 0; n < 85; n++)
                issue_request(random_cmd(), $urandom_range(99) < 50 ? 3'd0 : 3'($urandom),
                              key_pool[$urandom_range(NKEYS - 1)], 6'($urandom),
                              0, none);
            if (phase < 2) begin
                fill_dom = 3'($urandom);
                for (int n = 0; n < NKEYS; n++)
                    issue_request(CMD_REMOVE, 0, key_pool[n], 0, 0, none);
                for (int n = 0; n < 36; n++)
                    issue_request(CMD_PUT, fill_dom, key_pool[n], 0, 0, none);
                for (int n = 36; n < 70; n++)
                    issue_request(CMD_PUT, 3'($urandom), key_pool[n], 0, 0, none);
                issue_request(CMD_KEY_OF_ID, fill_dom, 0, 32, 0, none);
                issue_request(CMD_KEY_OF_ID, fill_dom, 0, 33, 0, none);
            end
        end
        @(posedge i_clk);
        i_valid <= 0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
